### rtl/dfsr_pkg.sv
// shared constants and types of the daq frame sample reassembler
package dfsr_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int BUFFER_SLOTS = 2;
    localparam int CHAN_W       = $clog2(MAX_CHANNELS);
    localparam int SLOT_W       = $clog2(BUFFER_SLOTS);

    typedef struct packed {
        logic [63:0] frame;
        logic [7:0]  source_node;
    } in_item_t;

    typedef struct packed {
        logic [15:0]        out_sample_index;
        logic [7:0]         out_node;
        logic [2:0]         out_channel;
        logic signed [31:0] out_value;
        logic               out_valid;
        logic [7:0]         out_channel_count;
        logic               out_last;
    } out_item_t;

    typedef struct packed {
        logic              accept;
        logic              load;
        logic [CHAN_W-1:0] chan;
        logic              last;
    } dfsr_cmd_t;

    typedef struct packed {
        logic complete;
    } dfsr_sts_t;

endpackage

### rtl/dfsr_ctrl.sv
// controller: request acceptance and result run sequencing
module dfsr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  dfsr_pkg::dfsr_sts_t sts,
    output dfsr_pkg::dfsr_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    localparam logic [dfsr_pkg::CHAN_W-1:0] LAST_CHAN =
        dfsr_pkg::CHAN_W'(dfsr_pkg::MAX_CHANNELS - 1);

    state_t                      state_reg, state_next;
    logic [dfsr_pkg::CHAN_W-1:0] chan_reg, chan_next;
    logic                        m_valid_reg, m_valid_next;
    logic                        accept;
    logic                        load;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign load    = (state_reg == ST_RUN) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;

    assign cmd.accept = accept;
    assign cmd.load   = load;
    assign cmd.chan   = chan_reg;
    assign cmd.last   = (chan_reg == LAST_CHAN);

    always_comb begin
        state_next   = state_reg;
        chan_next    = chan_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            m_valid_next = 1'b1;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept && sts.complete) begin
                    state_next = ST_RUN;
                    chan_next  = '0;
                end
            end
            ST_RUN: begin
                if (load) begin
                    chan_next = chan_reg + 1'b1;
                    if (chan_reg == LAST_CHAN) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            chan_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            chan_reg    <= chan_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### rtl/dfsr_datapath.sv
// datapath: two-slot sample buffer and result register
module dfsr_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  dfsr_pkg::in_item_t  s_data,
    input  dfsr_pkg::dfsr_cmd_t cmd,
    output dfsr_pkg::dfsr_sts_t sts,
    output dfsr_pkg::out_item_t m_data
);

    logic [dfsr_pkg::SLOT_W-1:0]       ptr_reg;
    logic [15:0]                       index_reg    [dfsr_pkg::BUFFER_SLOTS];
    logic [dfsr_pkg::MAX_CHANNELS-1:0] validity_reg [dfsr_pkg::BUFFER_SLOTS];
    logic [7:0]                        node_reg     [dfsr_pkg::BUFFER_SLOTS];
    logic [31:0] values_reg [dfsr_pkg::BUFFER_SLOTS][dfsr_pkg::MAX_CHANNELS];
    logic [7:0]                        count_reg;
    dfsr_pkg::out_item_t               out_reg;

    logic [15:0]                       f_index;
    logic [7:0]                        f_chan;
    logic [7:0]                        f_count;
    logic [31:0]                       f_value;
    logic [dfsr_pkg::CHAN_W-1:0]       chan_sel;
    logic                              in_range;
    logic                              switch_slot;
    logic [dfsr_pkg::SLOT_W-1:0]       slot;
    logic [dfsr_pkg::MAX_CHANNELS-1:0] validity_new;

    assign f_index  = s_data.frame[15:0];
    assign f_chan   = s_data.frame[23:16];
    assign f_count  = s_data.frame[31:24];
    assign f_value  = s_data.frame[63:32];
    assign chan_sel = f_chan[dfsr_pkg::CHAN_W-1:0];
    assign in_range = (f_chan < 8'(dfsr_pkg::MAX_CHANNELS));

    assign switch_slot = (index_reg[ptr_reg] != f_index);
    assign slot        = switch_slot ? ~ptr_reg : ptr_reg;

    always_comb begin
        validity_new = switch_slot ? '0 : validity_reg[slot];
        if (in_range) begin
            validity_new[chan_sel] = 1'b1;
        end
    end

    assign sts.complete = in_range && (f_count != 8'd0) && (f_chan == f_count - 8'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg   <= '0;
            count_reg <= '0;
            for (int i = 0; i < dfsr_pkg::BUFFER_SLOTS; i++) begin
                index_reg[i]    <= '0;
                validity_reg[i] <= '0;
                node_reg[i]     <= '0;
                for (int j = 0; j < dfsr_pkg::MAX_CHANNELS; j++) begin
                    values_reg[i][j] <= '0;
                end
            end
        end else if (cmd.accept) begin
            ptr_reg            <= slot;
            index_reg[slot]    <= f_index;
            validity_reg[slot] <= validity_new;
            if (in_range) begin
                node_reg[slot]             <= s_data.source_node;
                values_reg[slot][chan_sel] <= f_value;
            end
            if (sts.complete) begin
                count_reg <= f_count;
            end
        end
    end

    // result register, payload only
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_reg.out_sample_index  <= index_reg[ptr_reg];
            out_reg.out_node          <= node_reg[ptr_reg];
            out_reg.out_channel       <= 3'(cmd.chan);
            out_reg.out_value         <= values_reg[ptr_reg][cmd.chan];
            out_reg.out_valid         <= validity_reg[ptr_reg][cmd.chan];
            out_reg.out_channel_count <= count_reg;
            out_reg.out_last          <= cmd.last;
        end
    end

    assign m_data = out_reg;

endmodule

### rtl/daq_frame_sample_reassembler.sv
// top level of the daq frame sample reassembler
//
// the s_ channel takes one 8-byte frame (index, channel, count, value) and
// the sender's node id per request. the frame is written into the current
// slot of a two-slot sample buffer; a new sample index moves to the other
// slot and clears its validity mask first. frames for channels outside the
// buffer are dropped after the slot switch.
// a frame whose channel is the last one of its announced count triggers a
// run of eight results on the m_ channel, one per channel slot, out_last on
// the eighth. a frame that completes nothing leaves the s_ channel ready;
// a completing frame blocks it while the controller steps the channel
// counter through the buffer, one result per cycle into the output
// register. acceptance sets the run state, which loads the first result.
// when the receiver stalls, the run pauses with the output register held;
// the last result may wait there while the next frame is already taken.
// synchronous active-low reset clears m_valid, not the output payload, and
// sets both slots to sample index zero with values, node ids, masks cleared.
module daq_frame_sample_reassembler (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dfsr_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dfsr_pkg::out_item_t m_data
);

    dfsr_pkg::dfsr_cmd_t cmd;
    dfsr_pkg::dfsr_sts_t sts;

    dfsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dfsr_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_data  (m_data)
    );

endmodule

### tb/dfsr_tb_pkg.sv
// scoreboard that predicts the result runs of the daq frame sample reassembler
package dfsr_tb_pkg;
    import dfsr_pkg::*;

    class sample_run_scoreboard;
        bit          cur_slot;
        logic [15:0] slot_index [BUFFER_SLOTS];
        logic [7:0]  slot_mask  [BUFFER_SLOTS];
        logic [7:0]  slot_node  [BUFFER_SLOTS];
        logic [31:0] slot_value [BUFFER_SLOTS][MAX_CHANNELS];
        out_item_t   expected_channels [$];
        int          failures;

        function new();
            cur_slot = 1'b0;
            failures = 0;
            foreach (slot_index[s]) begin
                slot_index[s] = '0;
                slot_mask[s]  = '0;
                slot_node[s]  = '0;
                foreach (slot_value[s][c]) begin
                    slot_value[s][c] = '0;
                end
            end
        endfunction

        function void note_frame(in_item_t req);
            logic [15:0] idx;
            logic [7:0]  chan;
            logic [7:0]  cnt;
            logic [31:0] val;
            out_item_t   res;
            idx  = req.frame[15:0];
            chan = req.frame[23:16];
            cnt  = req.frame[31:24];
            val  = req.frame[63:32];

            if (slot_index[cur_slot] != idx) begin
                cur_slot = ~cur_slot;
                slot_index[cur_slot] = idx;
                slot_mask[cur_slot]  = '0;
            end
            if (chan >= MAX_CHANNELS) return;

            slot_value[cur_slot][chan[CHAN_W-1:0]] = val;
            slot_node[cur_slot] = req.source_node;
            slot_mask[cur_slot][chan[CHAN_W-1:0]] = 1'b1;
            if (cnt == 8'd0 || chan != cnt - 8'd1) return;

            for (int k = 0; k < MAX_CHANNELS; k++) begin
                res.out_sample_index  = slot_index[cur_slot];
                res.out_node          = slot_node[cur_slot];
                res.out_channel       = 3'(k);
                res.out_value         = slot_value[cur_slot][k];
                res.out_valid         = slot_mask[cur_slot][k];
                res.out_channel_count = cnt;
                res.out_last          = (k == MAX_CHANNELS - 1);
                expected_channels.push_back(res);
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_channels.size() == 0) begin
                $error("result with nothing expected: out_channel %0d", got.out_channel);
                failures++;
                return;
            end
            want = expected_channels.pop_front();
            if (got.out_sample_index !== want.out_sample_index) begin
                $error("out_sample_index expected %0h got %0h",
                       want.out_sample_index, got.out_sample_index);
                failures++;
            end
            if (got.out_node !== want.out_node) begin
                $error("out_node expected %0h got %0h", want.out_node, got.out_node);
                failures++;
            end
            if (got.out_channel !== want.out_channel) begin
                $error("out_channel expected %0d got %0d", want.out_channel, got.out_channel);
                failures++;
            end
            if (got.out_value !== want.out_value) begin
                $error("out_value expected %0d got %0d", want.out_value, got.out_value);
                failures++;
            end
            if (got.out_valid !== want.out_valid) begin
                $error("out_valid expected %0b got %0b", want.out_valid, got.out_valid);
                failures++;
            end
            if (got.out_channel_count !== want.out_channel_count) begin
                $error("out_channel_count expected %0d got %0d",
                       want.out_channel_count, got.out_channel_count);
                failures++;
            end
            if (got.out_last !== want.out_last) begin
                $error("out_last expected %0b got %0b", want.out_last, got.out_last);
                failures++;
            end
        endfunction

        function int pending_count();
            return expected_channels.size();
        endfunction
    endclass

endpackage

### tb/tb_top.sv
// testbench top of the daq frame sample reassembler
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dfsr_pkg::*;
    import dfsr_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE_TICKS = 16;
    localparam int PHASE_ITEMS  = 90;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;

    sample_run_scoreboard sb = new();

    daq_frame_sample_reassembler u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        m_ready     <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_data);
            if (s_valid && s_ready) sb.note_frame(s_data);
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_top NOT OK");
        $finish;
    end

    function automatic in_item_t make_frame(logic [15:0] idx, logic [7:0] chan,
                                            logic [7:0] cnt, logic [31:0] val,
                                            logic [7:0] node);
        in_item_t req;
        req.frame       = {val, cnt, chan, idx};
        req.source_node = node;
        return req;
    endfunction

    task automatic send_request(input in_item_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_count() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic run_random(input int n_items);
        int          sent;
        int          cnt;
        int          j;
        int          tmp;
        int          order [MAX_CHANNELS];
        logic [15:0] idx;
        logic [15:0] prev_idx;
        logic [7:0]  node;
        sent     = 0;
        prev_idx = '0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 80) begin
                // well-formed sample with random channel order and gaps
                idx  = ($urandom_range(3) == 0) ? prev_idx : 16'($urandom);
                cnt  = $urandom_range(1, MAX_CHANNELS);
                node = 8'($urandom);
                for (int i = 0; i < cnt - 1; i++) order[i] = i;
                for (int i = cnt - 2; i > 0; i--) begin
                    j        = $urandom_range(i);
                    tmp      = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                for (int i = 0; i < cnt - 1; i++) begin
                    if ($urandom_range(4) != 0) begin
                        if ($urandom_range(3) == 0) node = 8'($urandom);
                        send_request(make_frame(idx, 8'(order[i]), 8'(cnt), $urandom, node));
                        sent++;
                    end
                end
                send_request(make_frame(idx, 8'(cnt - 1), 8'(cnt), $urandom, node));
                sent++;
                prev_idx = idx;
            end else begin
                case ($urandom_range(2))
                    0: send_request(make_frame(16'($urandom), 8'($urandom), 8'($urandom),
                                               $urandom, 8'($urandom)));
                    1: send_request(make_frame(prev_idx, 8'($urandom_range(MAX_CHANNELS - 1)),
                                               8'($urandom_range(1) ? 0 : $urandom),
                                               $urandom, 8'($urandom)));
                    default: send_request(make_frame(prev_idx,
                                                     8'($urandom_range(MAX_CHANNELS, 255)),
                                                     8'($urandom), $urandom, 8'($urandom)));
                endcase
                sent++;
            end
            if ($urandom_range(29) == 0) wait_drained();
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fresh start: index zero stays in the first slot
        send_request(make_frame(16'h0000, 8'd0, 8'd1, 32'h7fff_ffff, 8'h00));
        send_request(make_frame(16'h0000, 8'd0, 8'd2, 32'h8000_0000, 8'hff));
        send_request(make_frame(16'h0000, 8'd1, 8'd2, 32'hffff_ffff, 8'hff));
        // out of range channels, the first one still switches slots
        send_request(make_frame(16'hffff, 8'd8, 8'd9, 32'h1234_5678, 8'h11));
        send_request(make_frame(16'hffff, 8'hff, 8'hff, 32'hffff_ffff, 8'hff));
        // zero count stores without completing
        send_request(make_frame(16'hffff, 8'd3, 8'd0, 32'haaaa_aaaa, 8'h55));
        // missing channels keep their old values
        send_request(make_frame(16'hffff, 8'd7, 8'd8, 32'h0000_0000, 8'haa));
        // count reported from the completing frame
        send_request(make_frame(16'h1234, 8'd5, 8'd6, 32'h5555_5555, 8'h01));
        send_request(make_frame(16'h1234, 8'd2, 8'd3, 32'hdead_beef, 8'h80));
        send_request(make_frame(16'h0000, 8'd0, 8'd1, 32'h0000_0001, 8'h7f));
        send_request(make_frame(16'h5555, 8'd7, 8'd1, 32'hcafe_f00d, 8'h42));
        for (int c = 1; c <= MAX_CHANNELS; c++) begin
            send_request(make_frame(16'h0100 + 16'(c), 8'(c - 1), 8'(c), $urandom, 8'(c)));
        end
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(PHASE_ITEMS);
        wait_drained();

        send_idle_pct  = 68;
        recv_stall_pct = 0;
        run_random(PHASE_ITEMS);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 68;
        run_random(PHASE_ITEMS);
        wait_drained();

        send_idle_pct  = 24;
        recv_stall_pct = 24;
        run_random(PHASE_ITEMS);
        wait_drained();

        if (sb.pending_count() != 0) begin
            $error("%0d expected results never arrived", sb.pending_count());
            sb.failures++;
        end
        if (sb.failures == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
